### rtl/sha512_pkg.sv
// ----------------------------------------------------------------------------
// SHA-512 hash core package
// Shared types, state encodings and the round and start-value constants.
// ----------------------------------------------------------------------------
package sha512_pkg;

    typedef struct packed {
        logic [63:0] word;
        logic        final_word;
    } t_qword;

    typedef enum logic [0:0] {
        FRONT_DATA,
        FRONT_PAD
    } t_front_state;

    typedef enum logic [1:0] {
        BACK_LOAD,
        BACK_ROUND,
        BACK_ADD,
        BACK_OUT
    } t_back_state;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int ROUNDS      = 80;

    function automatic logic [63:0] start_value(input logic mode, input logic [2:0] idx);
        logic [63:0] v;
        v = 64'h0;
        if (!mode) begin
            case (idx)
                3'd0: v = 64'h6a09e667f3bcc908;
                3'd1: v = 64'hbb67ae8584caa73b;
                3'd2: v = 64'h3c6ef372fe94f82b;
                3'd3: v = 64'ha54ff53a5f1d36f1;
                3'd4: v = 64'h510e527fade682d1;
                3'd5: v = 64'h9b05688c2b3e6c1f;
                3'd6: v = 64'h1f83d9abfb41bd6b;
                3'd7: v = 64'h5be0cd19137e2179;
                default: v = 64'h0;
            endcase
        end else begin
            case (idx)
                3'd0: v = 64'hcbbb9d5dc1059ed8;
                3'd1: v = 64'h629a292a367cd507;
                3'd2: v = 64'h9159015a3070dd17;
                3'd3: v = 64'h152fecd8f70e5939;
                3'd4: v = 64'h67332667ffc00b31;
                3'd5: v = 64'h8eb44a8768581511;
                3'd6: v = 64'hdb0c2e0d64f98fa7;
                3'd7: v = 64'h47b5481dbefa4fa4;
                default: v = 64'h0;
            endcase
        end
        return v;
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] i);
        logic [63:0] k;
        k = 64'h0;
        case (i)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

### rtl/sha512_front.sv
// ----------------------------------------------------------------------------
// SHA-512 front end
// Packs message bytes into whole 64-bit words and appends padding and length.
// ----------------------------------------------------------------------------
module sha512_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [63:0]        i_data_word,
    input  logic [3:0]         i_byte_count,
    input  logic               i_last_of_message,
    output logic               o_push,
    output sha512_pkg::t_qword o_qword,
    input  logic               i_full
);
    import sha512_pkg::*;

    t_front_state r_state, n_state;
    logic [63:0]  r_acc, n_acc;
    logic [2:0]   r_acc_n, n_acc_n;
    logic [3:0]   r_wpos, n_wpos;
    logic [63:0]  r_msg, n_msg;
    logic         r_first, n_first;
    logic         r_hold, n_hold;

    logic [3:0]   cnt;
    logic [63:0]  data_m;
    logic [127:0] comb_w;
    logic [4:0]   total;
    logic         accept;

    always_comb begin
        cnt    = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        data_m = i_data_word & ~({64{1'b1}} >> {cnt, 3'b000});
        comb_w = {r_acc, 64'h0} | ({data_m, 64'h0} >> {r_acc_n, 3'b000});
        total  = {2'b00, r_acc_n} + {1'b0, cnt};
        accept = i_valid && o_ready;
    end

    assign o_ready = (r_state == FRONT_DATA) && !i_full;

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_acc_n = r_acc_n;
        n_wpos  = r_wpos;
        n_msg   = r_msg;
        n_first = r_first;
        n_hold  = r_hold;
        o_push  = 1'b0;
        o_qword = '{word: comb_w[127:64], final_word: 1'b0};
        case (r_state)
            FRONT_DATA: begin
                if (accept) begin
                    n_msg = r_msg + {60'h0, cnt};
                    if (total >= 5'd8) begin
                        o_push  = 1'b1;
                        n_acc   = comb_w[63:0];
                        n_acc_n = 3'(total - 5'd8);
                        n_wpos  = r_wpos + 4'd1;
                    end else begin
                        n_acc   = comb_w[127:64];
                        n_acc_n = total[2:0];
                    end
                    if (i_last_of_message) begin
                        n_state = FRONT_PAD;
                        n_first = 1'b1;
                    end
                end
            end
            FRONT_PAD: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    n_wpos = r_wpos + 4'd1;
                    if (r_first) begin
                        o_qword.word = r_acc | (64'h8000_0000_0000_0000 >> {r_acc_n, 3'b000});
                        n_first = 1'b0;
                        n_hold  = (r_wpos >= 4'd14) && (r_wpos != 4'd15);
                    end else if (r_wpos == 4'd15 && !r_hold) begin
                        o_qword = '{word: {r_msg[60:0], 3'b000}, final_word: 1'b1};
                        n_state = FRONT_DATA;
                        n_acc   = 64'h0;
                        n_acc_n = 3'd0;
                        n_msg   = 64'h0;
                    end else begin
                        o_qword.word = 64'h0;
                        if (r_wpos == 4'd15) begin
                            n_hold = 1'b0;
                        end
                    end
                end
            end
            default: n_state = FRONT_DATA;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state <= FRONT_DATA;
            r_acc   <= 64'h0;
            r_acc_n <= 3'd0;
            r_wpos  <= 4'd0;
            r_msg   <= 64'h0;
            r_first <= 1'b0;
            r_hold  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_acc_n <= n_acc_n;
            r_wpos  <= n_wpos;
            r_msg   <= n_msg;
            r_first <= n_first;
            r_hold  <= n_hold;
        end
    end

endmodule

### rtl/sha512_fifo.sv
// ----------------------------------------------------------------------------
// SHA-512 word queue
// Small queue of padded message words between the front end and the rounds.
// ----------------------------------------------------------------------------
module sha512_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic               i_push,
    input  sha512_pkg::t_qword i_qword,
    output logic               o_full,
    input  logic               i_pop,
    output sha512_pkg::t_qword o_qword,
    output logic               o_empty
);
    import sha512_pkg::*;

    t_qword              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_qword = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            mem[r_wr] <= i_qword;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(i_push && !o_full)
                           - (QUEUE_AW+1)'(i_pop && !o_empty);
        end
    end

endmodule

### rtl/sha512_back.sv
// ----------------------------------------------------------------------------
// SHA-512 compression engine
// Loads 16 words, runs 80 rounds, folds into the chaining hash, emits digest.
// ----------------------------------------------------------------------------
module sha512_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  sha512_pkg::t_qword i_qword,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [63:0]        o_digest_word,
    output logic [2:0]         o_word_index,
    output logic               o_last_word
);
    import sha512_pkg::*;

    t_back_state r_state, n_state;
    logic        r_mode;
    logic [63:0] r_h [8];
    logic [63:0] n_h [8];
    logic [63:0] r_v [8];
    logic [63:0] n_v [8];
    logic [63:0] r_w [16];
    logic [63:0] n_w [16];
    logic [6:0]  r_cnt, n_cnt;
    logic        r_final, n_final;
    logic [2:0]  r_idx, n_idx;
    logic        r_oval, n_oval;
    logic [63:0] r_oword, n_oword;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_olast, n_olast;

    logic [63:0] t1, t2, wnew;
    logic [2:0]  last_idx;

    assign o_valid       = r_oval;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oidx;
    assign o_last_word   = r_olast;
    assign last_idx      = r_mode ? 3'd5 : 3'd7;

    always_comb begin
        t1 = r_v[7] + (rotr64(r_v[4], 14) ^ rotr64(r_v[4], 18) ^ rotr64(r_v[4], 41))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_cnt) + r_w[0];
        t2 = (rotr64(r_v[0], 28) ^ rotr64(r_v[0], 34) ^ rotr64(r_v[0], 39))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        wnew = r_w[0] + (rotr64(r_w[1], 1) ^ rotr64(r_w[1], 8) ^ (r_w[1] >> 7)) + r_w[9]
             + (rotr64(r_w[14], 19) ^ rotr64(r_w[14], 61) ^ (r_w[14] >> 6));
    end

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_v     = r_v;
        n_w     = r_w;
        n_cnt   = r_cnt;
        n_final = r_final;
        n_idx   = r_idx;
        n_oval  = r_oval;
        n_oword = r_oword;
        n_oidx  = r_oidx;
        n_olast = r_olast;
        o_pop   = 1'b0;
        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end
        case (r_state)
            BACK_LOAD: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    for (int i = 0; i < 15; i++) begin
                        n_w[i] = r_w[i+1];
                    end
                    n_w[15] = i_qword.word;
                    n_final = i_qword.final_word;
                    if (r_cnt == 7'd15) begin
                        n_cnt   = 7'd0;
                        n_v     = r_h;
                        n_state = BACK_ROUND;
                    end else begin
                        n_cnt = r_cnt + 7'd1;
                    end
                end
            end
            BACK_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = wnew;
                if (r_cnt == 7'(ROUNDS - 1)) begin
                    n_cnt   = 7'd0;
                    n_state = BACK_ADD;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            BACK_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_idx   = 3'd0;
                n_state = r_final ? BACK_OUT : BACK_LOAD;
            end
            BACK_OUT: begin
                if (!r_oval || i_ready) begin
                    n_oval  = 1'b1;
                    n_oword = r_h[r_idx];
                    n_oidx  = r_idx;
                    n_olast = (r_idx == last_idx);
                    if (r_idx == last_idx) begin
                        for (int i = 0; i < 8; i++) begin
                            n_h[i] = start_value(r_mode, 3'(i));
                        end
                        n_state = BACK_LOAD;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: n_state = BACK_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state <= BACK_LOAD;
            r_mode  <= i_rst_n ? i_cfg_wdata : 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= start_value(i_rst_n ? i_cfg_wdata : 1'b0, 3'(i));
            end
            r_cnt   <= 7'd0;
            r_final <= 1'b0;
            r_idx   <= 3'd0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_cnt   <= n_cnt;
            r_final <= n_final;
            r_idx   <= n_idx;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_w     <= n_w;
        r_oword <= n_oword;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
    end

endmodule

### rtl/sha512_hash_core.sv
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 hash core
// Streaming message hash with padding, length append and digest output.
// ----------------------------------------------------------------------------
// A 128-byte block is loaded into the round engine as 16 words, then runs
// 80 rounds and one fold into the chaining hash. After the last input beat,
// the first digest beat follows the padding words and one or two block
// passes when the round engine is idle at that beat.
// Reset is synchronous and active low; it selects SHA-512 and clears state.
module sha512_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha512_pkg::*;

    // The front end packs arbitrary byte runs into whole words and, on the
    // last beat of a message, generates the 0x80 marker, zero fill and the
    // bit length. Its words go through a short queue to the round engine,
    // which owns the chaining hash and the mode register.
    t_qword push_word, pop_word;
    logic   push, full, pop, empty;

    sha512_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_word       (i_data_word),
        .i_byte_count      (i_byte_count),
        .i_last_of_message (i_last_of_message),
        .o_push            (push),
        .o_qword           (push_word),
        .i_full            (full)
    );

    // A configuration write abandons any partial message, so the queue is
    // flushed along with the front and back state.
    sha512_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_push  (push),
        .i_qword (push_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_qword (pop_word),
        .o_empty (empty)
    );

    sha512_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_qword       (pop_word),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

### rtl/sha512_checker.sv
// ----------------------------------------------------------------------------
// SHA-512 port checker
// Watches the digest channel of the hash core over time.
// ----------------------------------------------------------------------------
module sha512_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_word))
        else $error("digest beat changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("digest valid after reset");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_word |-> (o_word_index == 3'd5 || o_word_index == 3'd7))
        else $error("final digest beat at wrong index");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_word) ##1 o_valid
            |-> o_word_index == $past(o_word_index) + 3'd1)
        else $error("digest beats out of order");

endmodule

bind sha512_hash_core sha512_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
